@@ src/mrfc_pkg.sv @@
// Shared types, codes and the CRC-16 byte step for the Modbus reply frame checker.
// No dependencies; imported by mrfc_frame_core and the top level.
`timescale 1ns / 1ps

package mrfc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CrcW    = 16;
  localparam int unsigned PosW    = 9;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CrcW-1:0] CrcPoly = 16'hA001;
  localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;

  // Fixed header bytes ahead of the payload: address, function, length.
  localparam logic [PosW-1:0] HdrLen = 9'd3;

  typedef enum logic [1:0] {
    REQ_START   = 2'd0,
    REQ_BYTE    = 2'd1,
    REQ_TIMEOUT = 2'd2,
    REQ_NONE    = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_PROGRESS = 3'd0,
    ST_PAYLOAD  = 3'd1,
    ST_FRAME_OK = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_TIMEOUT  = 3'd4,
    ST_IGNORED  = 3'd5
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SLAVE_ADDR = 2'd0,
    CFG_FUNC_CODE  = 2'd1,
    CFG_RX_CAP     = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [ByteW-1:0] slave_address;
    logic [ByteW-1:0] function_code;
    logic [ByteW-1:0] receive_capacity;
  } cfg_t;

  typedef struct packed {
    status_t          status;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] payload_index;
    logic [ByteW-1:0] frame_length;
  } result_t;

  // One byte through the reflected CRC-16, LSB first.
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] acc,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = acc ^ {8'h00, b};
    for (int k = 0; k < ByteW; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ src/mrfc_frame_core.sv @@
// Frame parser state and per-beat decision logic for the Modbus reply checker.
// Depends on mrfc_pkg (codes, result struct, CRC byte step).
`timescale 1ns / 1ps

module mrfc_frame_core
  import mrfc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_i,
  input  req_t             req_i,
  input  logic [ByteW-1:0] byte_i,
  input  cfg_t             cfg_i,
  output result_t          res_o
);

  logic             armed_r,   armed_nxt;
  logic [PosW-1:0]  pos_r,     pos_nxt;
  logic [ByteW-1:0] len_r,     len_nxt;
  logic [CrcW-1:0]  crc_r,     crc_nxt;

  logic [CrcW-1:0]  crc_in;
  logic [CrcW-1:0]  crc_step;
  logic [PosW-1:0]  crc_lo_pos;
  logic [PosW-1:0]  pay_idx;
  result_t          res;

  // The address byte restarts the CRC from its initial value.
  assign crc_in     = (pos_r == '0) ? CrcInit : crc_r;
  assign crc_step   = crc_byte(crc_in, byte_i);
  assign crc_lo_pos = HdrLen + {1'b0, len_r};
  assign pay_idx    = pos_r - HdrLen;

  always_comb begin
    armed_nxt = armed_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    crc_nxt   = crc_r;
    res       = '{status: ST_PROGRESS, payload_byte: '0, payload_index: '0,
                  frame_length: '0};
    if (req_i == REQ_START) begin
      armed_nxt = 1'b1;
      pos_nxt   = '0;
      len_nxt   = '0;
      crc_nxt   = CrcInit;
    end else if (!armed_r) begin
      res.status = ST_IGNORED;
    end else if (req_i == REQ_TIMEOUT) begin
      armed_nxt  = 1'b0;
      res.status = ST_TIMEOUT;
    end else if (req_i == REQ_NONE) begin
      res.status = ST_PROGRESS;
    end else if (pos_r == 9'd0) begin
      if (byte_i == cfg_i.slave_address) begin
        crc_nxt = crc_step;
        pos_nxt = 9'd1;
      end else begin
        armed_nxt  = 1'b0;
        res.status = ST_MISMATCH;
      end
    end else if (pos_r == 9'd1) begin
      if (byte_i == cfg_i.function_code) begin
        crc_nxt = crc_step;
        pos_nxt = 9'd2;
      end else begin
        armed_nxt  = 1'b0;
        res.status = ST_MISMATCH;
      end
    end else if (pos_r == 9'd2) begin
      len_nxt = byte_i;
      crc_nxt = crc_step;
      pos_nxt = HdrLen;
    end else if (pos_r < crc_lo_pos) begin
      crc_nxt = crc_step;
      pos_nxt = pos_r + 9'd1;
      if (pay_idx[ByteW-1:0] < cfg_i.receive_capacity) begin
        res.status        = ST_PAYLOAD;
        res.payload_byte  = byte_i;
        res.payload_index = pay_idx[ByteW-1:0];
      end
    end else if (pos_r == crc_lo_pos) begin
      if (byte_i == crc_r[7:0]) begin
        pos_nxt = pos_r + 9'd1;
      end else begin
        armed_nxt  = 1'b0;
        res.status = ST_MISMATCH;
      end
    end else begin
      armed_nxt = 1'b0;
      if (byte_i == crc_r[15:8]) begin
        res.status       = ST_FRAME_OK;
        res.frame_length = len_r;
      end else begin
        res.status = ST_MISMATCH;
      end
    end
  end

  assign res_o = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      pos_r   <= '0;
      len_r   <= '0;
      crc_r   <= CrcInit;
    end else if (step_i) begin
      armed_r <= armed_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      crc_r   <= crc_nxt;
    end
  end

  // A good CRC high byte always closes the frame.
  a_ok_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && res.status == ST_FRAME_OK |=> !armed_r)
    else $error("parser still armed after frame ok");

  // Start clears the parser whatever it was doing.
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && req_i == REQ_START |=> armed_r && pos_r == '0 && len_r == '0 &&
    crc_r == CrcInit)
    else $error("start did not clear parser state");

  // Position never runs past the CRC high byte of the current length.
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= HdrLen + {1'b0, len_r} + 9'd1)
    else $error("byte position beyond frame end");

  // Non-start beats while idle are only reported as ignored.
  a_idle_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    step_i && !armed_r && req_i != REQ_START |-> res.status == ST_IGNORED &&
    armed_nxt == 1'b0)
    else $error("idle parser reacted to a beat");

endmodule

@@ src/modbus_response_frame_checker_unit.sv @@
// Top level of the Modbus RTU reply frame checker: input stage, result stage,
// configuration registers. Depends on mrfc_pkg and mrfc_frame_core.
//
//   channel | ports                                         | direction
//   --------+-----------------------------------------------+----------
//   in      | in_valid, in_ready, in_req_type, in_rx_byte   | to block
//   out     | out_valid, out_ready, out_status,             | from block
//           | out_payload_byte, out_payload_index,          |
//           | out_frame_length                              |
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data     | to block
//
// Each beat is held in the input register, then decoded, CRC stepped (one full
// 8-bit CRC-16 step) and written to the result register; one beat per cycle is
// sustained while out_ready stays high.
// rst_n is synchronous, active low; it idles the parser and loads the register
// defaults (address 1, function 1, capacity 3). cfg is always ready.
// A stalled out_ready holds the result register and then the input register;
// in_ready drops only when both are full and the result is not being taken.
`timescale 1ns / 1ps

module modbus_response_frame_checker_unit
  import mrfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic [ByteW-1:0]   in_rx_byte,

  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [ByteW-1:0]   out_payload_byte,
  output logic [ByteW-1:0]   out_payload_index,
  output logic [ByteW-1:0]   out_frame_length,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ByteW-1:0]   cfg_data
);

  // Input stage
  logic             s1_valid_r;
  req_t             s1_req_r;
  logic [ByteW-1:0] s1_byte_r;

  // Result stage
  logic             out_valid_r;
  result_t          out_res_r;

  cfg_t             cfg_r;
  result_t          core_res;
  logic             out_adv;
  logic             s1_adv;
  logic             step;

  // Result register frees up when empty or being drained this cycle.
  assign out_adv  = !out_valid_r || out_ready;
  assign step     = s1_valid_r && out_adv;
  assign s1_adv   = !s1_valid_r || out_adv;
  assign in_ready = s1_adv;

  assign cfg_ready = 1'b1;

  // Configuration registers; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slave_address    <= 8'd1;
      cfg_r.function_code    <= 8'd1;
      cfg_r.receive_capacity <= 8'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SLAVE_ADDR: cfg_r.slave_address    <= cfg_data;
        CFG_FUNC_CODE:  cfg_r.function_code    <= cfg_data;
        CFG_RX_CAP:     cfg_r.receive_capacity <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: capture a beat whenever the stage can advance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1_req_r  <= req_t'(in_req_type);
      s1_byte_r <= in_rx_byte;
    end
  end

  mrfc_frame_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (step),
    .req_i  (s1_req_r),
    .byte_i (s1_byte_r),
    .cfg_i  (cfg_r),
    .res_o  (core_res)
  );

  // Result register: load on a parser step, hold while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_payload_byte  = out_res_r.payload_byte;
  assign out_payload_index = out_res_r.payload_index;
  assign out_frame_length  = out_res_r.frame_length;

  // A held result is not overwritten while the sink stalls.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_res_r))
    else $error("result changed under stall");

  // The parser only steps when the result register can take its output.
  a_step_room: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("parser step lost its result");

  // A full pipe with a stalled sink refuses new beats.
  a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input accepted with no room");

endmodule

@@ test/tb_modbus_response_frame_checker_unit.sv @@
// Self-checking testbench for modbus_response_frame_checker_unit: drives reply frames,
// noise and register writes, and checks every result beat against its own frame parser.
// Depends on mrfc_pkg (codes and result layout) and the RTL under src/.
`timescale 1ns / 1ps

module tb_modbus_response_frame_checker_unit;
  import mrfc_pkg::*;

  localparam logic [15:0] ReplyCrcPoly = 16'hA001;
  localparam logic [15:0] ReplyCrcSeed = 16'hFFFF;
  localparam int unsigned RunLimitNs   = 400_000;
  localparam int unsigned PhaseBeats   = 200;

  // Tracks what the block should answer for each accepted input beat and
  // checks result beats in order against it.
  class reply_scoreboard;
    logic [7:0]  addr_reg;
    logic [7:0]  func_reg;
    logic [7:0]  cap_reg;
    bit          armed;
    logic [8:0]  pos;
    logic [7:0]  plen;
    logic [15:0] crc;
    result_t     expected_replies[$];
    int          errors;
    int          useful_beats;

    function new();
      addr_reg     = 8'd1;
      func_reg     = 8'd1;
      cap_reg      = 8'd3;
      armed        = 1'b0;
      pos          = '0;
      plen         = '0;
      crc          = ReplyCrcSeed;
      errors       = 0;
      useful_beats = 0;
    endfunction

    // Reflected CRC-16, one byte, LSB first.
    static function logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {8'h00, b};
      repeat (8) c = c[0] ? ((c >> 1) ^ ReplyCrcPoly) : (c >> 1);
      return c;
    endfunction

    function void load_reg(cfg_idx_t idx, logic [7:0] v);
      case (idx)
        CFG_SLAVE_ADDR: addr_reg = v;
        CFG_FUNC_CODE:  func_reg = v;
        CFG_RX_CAP:     cap_reg  = v;
        default: ;
      endcase
    endfunction

    // Advance the parser by one accepted beat and queue the reply it causes.
    function void note_rx_beat(req_t req, logic [7:0] b);
      result_t r;
      int      lo_pos;
      int      idx;
      r        = '0;
      r.status = ST_PROGRESS;
      lo_pos   = 3 + int'(plen);
      idx      = int'(pos) - 3;
      if (req == REQ_START) begin
        armed = 1'b1;
        pos   = '0;
        plen  = '0;
        crc   = ReplyCrcSeed;
      end else if (!armed) begin
        r.status = ST_IGNORED;
      end else if (req == REQ_TIMEOUT) begin
        armed    = 1'b0;
        r.status = ST_TIMEOUT;
      end else if (req == REQ_NONE) begin
        // no meaning while armed: hold all state
      end else if (pos == 0) begin
        if (b == addr_reg) begin
          crc = crc16_step(ReplyCrcSeed, b);
          pos = 9'd1;
        end else begin
          armed    = 1'b0;
          r.status = ST_MISMATCH;
        end
      end else if (pos == 1) begin
        if (b == func_reg) begin
          crc = crc16_step(crc, b);
          pos = 9'd2;
        end else begin
          armed    = 1'b0;
          r.status = ST_MISMATCH;
        end
      end else if (pos == 2) begin
        plen = b;
        crc  = crc16_step(crc, b);
        pos  = 9'd3;
      end else if (int'(pos) < lo_pos) begin
        crc = crc16_step(crc, b);
        if (idx < int'(cap_reg)) begin
          r.status        = ST_PAYLOAD;
          r.payload_byte  = b;
          r.payload_index = idx[7:0];
        end
        pos = pos + 9'd1;
      end else if (int'(pos) == lo_pos) begin
        if (b == crc[7:0]) begin
          pos = pos + 9'd1;
        end else begin
          armed    = 1'b0;
          r.status = ST_MISMATCH;
        end
      end else begin
        armed = 1'b0;
        if (b == crc[15:8]) begin
          r.status       = ST_FRAME_OK;
          r.frame_length = plen;
        end else begin
          r.status = ST_MISMATCH;
        end
      end
      if (r.status != ST_IGNORED) useful_beats++;
      expected_replies.push_back(r);
    endfunction

    function void compare_field(string what, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_reply(logic [2:0] st, logic [7:0] pb, logic [7:0] pi,
                              logic [7:0] fl);
      result_t want;
      if (expected_replies.size() == 0) begin
        $display("%0t: result beat with status %0d, none expected", $time, st);
        errors++;
        return;
      end
      want = expected_replies.pop_front();
      compare_field("status", {5'd0, want.status}, {5'd0, st});
      compare_field("payload_byte", want.payload_byte, pb);
      compare_field("payload_index", want.payload_index, pi);
      compare_field("frame_length", want.frame_length, fl);
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_req_type;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] out_status;
  logic [7:0] out_payload_byte;
  logic [7:0] out_payload_index;
  logic [7:0] out_frame_length;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  // Random gaps on both channels while set; cleared for one burst phase.
  bit idle_on = 1'b1;

  reply_scoreboard replies = new();

  modbus_response_frame_checker_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RunLimitNs);
    $display("** modbus_response_frame_checker_unit: FAILED **");
    $finish;
  end

  // Observe all three channels at the edge, before any driver update lands.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) replies.load_reg(cfg_idx_t'(cfg_index), cfg_data);
      if (in_valid && in_ready) replies.note_rx_beat(req_t'(in_req_type), in_rx_byte);
      if (out_valid && out_ready) begin
        replies.check_reply(out_status, out_payload_byte, out_payload_index,
                            out_frame_length);
      end
    end
  end

  // Result side: draw a stall per beat, then hold ready until a beat is taken.
  initial begin : result_sink
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  // Offer one input beat after a random gap; return at the accepting edge.
  // Valid is left high so back-to-back beats never drop it.
  task automatic send_beat(input req_t r, input logic [7:0] b);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= r;
    in_rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Send a start beat and then a full reply frame with a valid CRC.
  // fault_at flips one frame byte; cut_at replaces that byte with cut_req
  // and drops the rest of the frame. Negative values disable either.
  task automatic send_reply(input logic [7:0] addr, input logic [7:0] func,
                            input int len, input int fault_at, input int cut_at,
                            input req_t cut_req);
    logic [7:0]  frame[$];
    logic [15:0] crc;
    crc = ReplyCrcSeed;
    frame.push_back(addr);
    frame.push_back(func);
    frame.push_back(len[7:0]);
    for (int i = 0; i < len; i++) frame.push_back(8'($urandom_range(0, 255)));
    for (int i = 0; i < frame.size(); i++) crc = reply_scoreboard::crc16_step(crc, frame[i]);
    frame.push_back(crc[7:0]);
    frame.push_back(crc[15:8]);
    if (fault_at >= 0 && fault_at < frame.size()) begin
      frame[fault_at] = frame[fault_at] ^ 8'($urandom_range(1, 255));
    end
    send_beat(REQ_START, 8'($urandom_range(0, 255)));
    for (int i = 0; i < frame.size(); i++) begin
      if (i == cut_at) begin
        send_beat(cut_req, 8'($urandom_range(0, 255)));
        return;
      end
      // sprinkle the meaningless request code into live frames
      if ($urandom_range(0, 19) == 0) send_beat(REQ_NONE, 8'($urandom_range(0, 255)));
      send_beat(REQ_BYTE, frame[i]);
    end
  endtask

  // Mostly short frames, a few medium, rarely the longest payload.
  task automatic random_reply();
    int   len;
    int   roll;
    int   fault_at;
    int   cut_at;
    req_t cut_req;
    roll     = $urandom_range(0, 99);
    len      = (roll < 1) ? 255 : (roll < 10) ? $urandom_range(11, 40) : $urandom_range(0, 10);
    fault_at = -1;
    cut_at   = -1;
    cut_req  = REQ_TIMEOUT;
    roll     = $urandom_range(0, 99);
    if (roll < 20) begin
      fault_at = $urandom_range(0, len + 4);
    end else if (roll < 30) begin
      cut_at = $urandom_range(0, len + 4);
    end else if (roll < 35) begin
      cut_at  = $urandom_range(0, len + 4);
      cut_req = REQ_START;
    end
    send_reply(replies.addr_reg, replies.func_reg, len, fault_at, cut_at, cut_req);
  endtask

  // Drop input valid and wait until every queued reply has come back.
  // Advance to the next edge first so the last accepted beat is already queued.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies.expected_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all registers back to back; the unused index gets noise.
  task automatic write_config(input logic [7:0] addr, input logic [7:0] func,
                              input logic [7:0] cap);
    cfg_idx_t idx[4];
    logic [7:0] val[4];
    idx = '{CFG_SLAVE_ADDR, CFG_FUNC_CODE, CFG_RX_CAP, CFG_UNUSED};
    val = '{addr, func, cap, 8'($urandom_range(0, 255))};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int phase_base;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_req_type <= REQ_START;
    in_rx_byte  <= 8'h00;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_SLAVE_ADDR;
    cfg_data    <= 8'h00;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, on the reset register values (address 1, function 1,
    // capacity 3). Bytes and timeouts while idle are ignored.
    send_beat(REQ_BYTE, 8'hFF);
    send_beat(REQ_TIMEOUT, 8'h00);
    // arm, poke with the meaningless code, then restart while armed
    send_beat(REQ_START, 8'h00);
    send_beat(REQ_NONE, 8'hFF);
    send_reply(8'd1, 8'd1, 0, -1, -1, REQ_TIMEOUT);      // empty payload, ok
    send_reply(8'd1, 8'd1, 4, -1, -1, REQ_TIMEOUT);      // last byte past capacity
    send_reply(8'd2, 8'd1, 0, -1, -1, REQ_TIMEOUT);      // wrong address
    send_reply(8'd1, 8'd3, 0, -1, -1, REQ_TIMEOUT);      // wrong function
    send_reply(8'd1, 8'd1, 2, -1, 3, REQ_TIMEOUT);       // timeout in payload
    send_reply(8'd1, 8'd1, 0, 4, -1, REQ_TIMEOUT);       // bad CRC high byte

    // Random phases, each on its own register setting; extremes first.
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: write_config(8'h00, 8'h00, 8'h00);
        1: write_config(8'hFF, 8'hFF, 8'hFF);
        2: write_config(8'h01, 8'h03, 8'd3);
        default: begin
          write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 12)));
        end
      endcase
      idle_on    = (ph != 3);
      phase_base = replies.useful_beats;
      while (replies.useful_beats - phase_base < PhaseBeats) begin
        if ($urandom_range(0, 3) != 0) begin
          random_reply();
        end else begin
          repeat ($urandom_range(1, 6)) begin
            send_beat(req_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
          end
        end
      end
    end

    // Drain, then give the pipeline a few more edges to show stray beats.
    idle_on = 1'b1;
    settle();
    repeat (8) @(posedge clk);
    if (replies.expected_replies.size() != 0) begin
      $display("%0t: %0d expected replies never arrived", $time,
               replies.expected_replies.size());
      replies.errors++;
    end
    if (replies.errors == 0) begin
      $display("** modbus_response_frame_checker_unit: PASSED **");
    end else begin
      $display("** modbus_response_frame_checker_unit: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/mrfc_pkg.sv
src/mrfc_frame_core.sv
src/modbus_response_frame_checker_unit.sv
test/tb_modbus_response_frame_checker_unit.sv
